// ===== sv/dsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the disjoint-set union-find block.
package dsu_pkg;

   localparam int unsigned MaxElements = 1024;
   localparam int unsigned IdxW        = 10;
   localparam int unsigned CntW        = 11;
   localparam int unsigned RankW       = 4;

   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_UNION = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef logic [IdxW-1:0]  idx_type;
   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [RankW-1:0] rank_type;

   typedef struct packed {
      idx_type  parent;
      rank_type rank;
      cnt_type  size;
   } node_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      node_type wr_data;
      idx_type  rd_addr;
   } mem_req_type;

   typedef struct packed {
      idx_type first_root;
      idx_type second_root;
      logic    same_set;
      cnt_type set_count;
      cnt_type first_set_size;
      logic    index_error;
   } result_type;

endpackage

// ===== sv/disjoint_set_union_find.sv =====
`timescale 1ns / 1ps
// A query or union walks the parent path of each element up to its root, then compresses that
// path by pointing each node on it at the root; a merging union also links the two roots and
// writes the new root's size and rank. An index error goes straight to the result; a clear
// rewrites the node memory, one write per entry. One beat is in work at a time; the node memory,
// with one read and one write port, bounds the rate. After reset a sweep initializes the node
// memory with req_tready low. The element count register resets to 1024.
module disjoint_set_union_find (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // first_element, second_element, zero fill
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // first_root, second_root, same_set, set_count,
                                    // first_set_size, zero fill
   output logic        rsp_tuser,   // index_error
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   dsu_pkg::cnt_type     element_count_ff;
   dsu_pkg::mem_req_type mem_req;
   dsu_pkg::node_type    rd_data;
   dsu_pkg::result_type  result;
   logic                 done;
   logic                 rsp_free;
   logic                 rsp_valid_ff;
   logic [47:0]          rsp_data_ff;
   logic                 rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= dsu_pkg::CntW'(dsu_pkg::MaxElements);
      end else if (csr_wr_en) begin
         element_count_ff <= csr_wr_data;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   dsu_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   dsu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_cmd       (req_tuser),
      .req_a         (req_tdata[9:0]),
      .req_b         (req_tdata[19:10]),
      .element_count (element_count_ff),
      .rsp_free      (rsp_free),
      .done          (done),
      .result        (result),
      .mem_req       (mem_req),
      .rd_data       (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= {5'd0, result.first_set_size, result.set_count, result.same_set,
                         result.second_root, result.first_root};
         rsp_err_ff  <= result.index_error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== sv/dsu_table.sv =====
`timescale 1ns / 1ps
// Node memory holding parent, rank and size of every element.
module dsu_table (
   input  logic                 clock,
   input  dsu_pkg::mem_req_type mem_req,
   output dsu_pkg::node_type    rd_data
);

   dsu_pkg::node_type mem_ff [dsu_pkg::MaxElements];
   dsu_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dsu_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that walks, compresses and links the node memory for each beat.
module dsu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  dsu_pkg::idx_type     req_a,
   input  dsu_pkg::idx_type     req_b,
   input  dsu_pkg::cnt_type     element_count,
   input  logic                 rsp_free,
   output logic                 done,
   output dsu_pkg::result_type  result,
   output dsu_pkg::mem_req_type mem_req,
   input  dsu_pkg::node_type    rd_data
);

   typedef enum logic [6:0] {
      ST_SWEEP = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_UP    = 7'b0000100,
      ST_CMP   = 7'b0001000,
      ST_LINK  = 7'b0010000,
      ST_GROW  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   dsu_pkg::idx_type    sweep_ff, sweep_in;
   logic                from_clear_ff, from_clear_in;
   logic [1:0]          cmd_ff, cmd_in;
   dsu_pkg::idx_type    a_ff, a_in, b_ff, b_in;
   dsu_pkg::idx_type    walk_ff, walk_in;
   dsu_pkg::idx_type    root_ff, root_in;
   dsu_pkg::node_type   root_node_ff, root_node_in;
   dsu_pkg::idx_type    ra_ff, ra_in;
   dsu_pkg::node_type   ra_node_ff, ra_node_in;
   logic                phase_ff, phase_in;
   dsu_pkg::cnt_type    active_ff, active_in;
   dsu_pkg::cnt_type    disjoint_ff, disjoint_in;
   dsu_pkg::result_type res_ff, res_in;
   dsu_pkg::cnt_type    eff_count;
   dsu_pkg::cnt_type    new_disjoint;
   dsu_pkg::node_type   node_tmp;
   logic                same;

   always_comb begin
      if (element_count == '0) begin
         eff_count = dsu_pkg::CntW'(1);
      end else if (element_count > dsu_pkg::CntW'(dsu_pkg::MaxElements)) begin
         eff_count = dsu_pkg::CntW'(dsu_pkg::MaxElements);
      end else begin
         eff_count = element_count;
      end
   end

   always_comb begin
      state_in         = state_ff;
      sweep_in         = sweep_ff;
      from_clear_in    = from_clear_ff;
      cmd_in           = cmd_ff;
      a_in             = a_ff;
      b_in             = b_ff;
      walk_in          = walk_ff;
      root_in          = root_ff;
      root_node_in     = root_node_ff;
      ra_in            = ra_ff;
      ra_node_in       = ra_node_ff;
      phase_in         = phase_ff;
      active_in        = active_ff;
      disjoint_in      = disjoint_ff;
      res_in           = res_ff;
      req_ready        = 1'b0;
      done             = 1'b0;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = walk_ff;
      mem_req.wr_data  = rd_data;
      mem_req.rd_addr  = walk_ff;
      same             = (ra_ff == root_ff);
      new_disjoint     = disjoint_ff - dsu_pkg::CntW'(disjoint_ff != '0);
      node_tmp         = rd_data;
      unique case (state_ff)
         ST_SWEEP: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = sweep_ff;
            mem_req.wr_data.parent = sweep_ff;
            mem_req.wr_data.rank   = '0;
            mem_req.wr_data.size   = dsu_pkg::CntW'(1);
            sweep_in               = sweep_ff + dsu_pkg::IdxW'(1);
            if (sweep_ff == dsu_pkg::IdxW'(dsu_pkg::MaxElements - 1)) begin
               sweep_in = '0;
               state_in = from_clear_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready       = 1'b1;
            mem_req.rd_addr = req_a;
            if (req_valid) begin
               cmd_in = req_cmd;
               a_in   = req_a;
               b_in   = req_b;
               res_in = '0;
               if (req_cmd == dsu_pkg::CMD_CLEAR) begin
                  active_in        = eff_count;
                  disjoint_in      = eff_count;
                  res_in.set_count = eff_count;
                  sweep_in         = '0;
                  from_clear_in    = 1'b1;
                  state_in         = ST_SWEEP;
               end else if ({1'b0, req_a} >= active_ff || {1'b0, req_b} >= active_ff) begin
                  res_in.set_count   = disjoint_ff;
                  res_in.index_error = 1'b1;
                  state_in           = ST_DONE;
               end else begin
                  walk_in  = req_a;
                  phase_in = 1'b0;
                  state_in = ST_UP;
               end
            end
         end
         ST_UP: begin
            if (rd_data.parent == walk_ff) begin
               root_in         = walk_ff;
               root_node_in    = rd_data;
               walk_in         = phase_ff ? b_ff : a_ff;
               mem_req.rd_addr = phase_ff ? b_ff : a_ff;
               state_in        = ST_CMP;
            end else begin
               walk_in         = rd_data.parent;
               mem_req.rd_addr = rd_data.parent;
            end
         end
         ST_CMP: begin
            if (walk_ff == root_ff) begin
               if (!phase_ff) begin
                  ra_in           = root_ff;
                  ra_node_in      = root_node_ff;
                  phase_in        = 1'b1;
                  walk_in         = b_ff;
                  mem_req.rd_addr = b_ff;
                  state_in        = ST_UP;
               end else begin
                  state_in = ST_LINK;
               end
            end else begin
               mem_req.wr_en          = 1'b1;
               mem_req.wr_addr        = walk_ff;
               mem_req.wr_data.parent = root_ff;
               walk_in                = rd_data.parent;
               mem_req.rd_addr        = rd_data.parent;
            end
         end
         ST_LINK: begin
            res_in.first_root     = ra_ff;
            res_in.second_root    = root_ff;
            res_in.same_set       = same;
            res_in.index_error    = 1'b0;
            res_in.set_count      = disjoint_ff;
            res_in.first_set_size = ra_node_ff.size;
            state_in              = ST_DONE;
            if (cmd_ff == dsu_pkg::CMD_UNION && !same) begin
               disjoint_in      = new_disjoint;
               res_in.set_count = new_disjoint;
               mem_req.wr_en    = 1'b1;
               state_in         = ST_GROW;
               if (ra_node_ff.rank > root_node_ff.rank) begin
                  node_tmp         = root_node_ff;
                  node_tmp.parent  = ra_ff;
                  mem_req.wr_addr  = root_ff;
                  mem_req.wr_data  = node_tmp;
                  root_in          = ra_ff;
                  root_node_in     = ra_node_ff;
                  root_node_in.size = ra_node_ff.size + root_node_ff.size;
               end else begin
                  node_tmp         = ra_node_ff;
                  node_tmp.parent  = root_ff;
                  mem_req.wr_addr  = ra_ff;
                  mem_req.wr_data  = node_tmp;
                  root_node_in.size = ra_node_ff.size + root_node_ff.size;
                  if (ra_node_ff.rank == root_node_ff.rank && root_node_ff.rank != '1) begin
                     root_node_in.rank = root_node_ff.rank + dsu_pkg::RankW'(1);
                  end
               end
               res_in.first_set_size = ra_node_ff.size + root_node_ff.size;
            end
         end
         ST_GROW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = root_ff;
            mem_req.wr_data = root_node_ff;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            done = rsp_free;
            if (rsp_free) begin
               from_clear_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         from_clear_ff <= 1'b0;
         active_ff     <= dsu_pkg::CntW'(dsu_pkg::MaxElements);
         disjoint_ff   <= dsu_pkg::CntW'(dsu_pkg::MaxElements);
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         from_clear_ff <= from_clear_in;
         active_ff     <= active_in;
         disjoint_ff   <= disjoint_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      walk_ff      <= walk_in;
      root_ff      <= root_in;
      root_node_ff <= root_node_in;
      ra_ff        <= ra_in;
      ra_node_ff   <= ra_node_in;
      phase_ff     <= phase_in;
      res_ff       <= res_in;
   end

   assign result = res_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && mem_req.wr_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("Compression write collides with the next read.");

   assert property (@(posedge clock) disable iff (reset)
      disjoint_ff <= active_ff)
      else $error("Set count exceeds the active element count.");

   assert property (@(posedge clock) disable iff (reset)
      active_ff != '0 && active_ff <= dsu_pkg::CntW'(dsu_pkg::MaxElements))
      else $error("Active element count out of range.");

   assert property (@(posedge clock) disable iff (reset)
      (done && res_ff.index_error) |-> (res_ff.first_set_size == '0))
      else $error("Rejected beat reports a set size.");
`endif

endmodule
